// ===== design/sbb_pkg.sv =====
// shared types and constants of the separable box blur
package sbb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_RADIUS_DEF = 15;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_EDGES = 2'd3;

    localparam logic [10:0] WIDTH_RST  = 11'd1024;
    localparam logic [10:0] HEIGHT_RST = 11'd1024;
    localparam logic [3:0]  RADIUS_RST = 4'd1;
    localparam logic        REPEAT_RST = 1'b0;

    localparam logic FUNC_PUSH = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TAP,
        S_FLUSH,
        S_DIV,
        S_STORE,
        S_EMIT
    } state_t;

endpackage

// ===== design/separable_box_blur_top.sv =====
// separable box blur of one rgba8 frame, line store and row buffer in block memories
//
//  channel   | dir | transfer when           | content
//  ----------+-----+-------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid & tready  | source pixel or drain tick
//  m_axis    | out | m_axis_tvalid & tready  | blurred pixel, tlast on frame end
//  cfg       | in  | cfg_we                  | frame_width/height, blur_radius, repeat
//
// an item passes through idle and a check step when no result is due; a push that closes horizontal windows
// adds per window one row buffer read per tap, 8 divide steps and a store,
// up to r+1 windows at a row end; a result adds its line store taps and the divide.
// the taps go one at a time through the single read port of each memory.
// rst_n clears control and config only; memories are not cleared.
// a result waiting on m_axis holds the sequencer in its output step; input stalls then.
module separable_box_blur_top #(
    parameter int MAX_WIDTH  = sbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbb_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = sbb_pkg::MAX_RADIUS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
    input  logic                            s_axis_tuser,  // func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [sbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import sbb_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int RADW  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int DW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int SLOTW = DW;
    localparam int SUMW  = 8 + DW;
    localparam int LW    = (CW > RW) ? CW : RW;
    localparam int PW    = LW + RADW + 1;
    localparam int LSAW  = SLOTW + XW;

    // configuration
    logic [10:0]      width_reg;
    logic [10:0]      height_reg;
    logic [3:0]       radius_reg;
    logic             repeat_reg;
    logic [CW-1:0]    w_eff;
    logic [RW-1:0]    h_eff;
    logic [RADW-1:0]  r_eff;
    logic [DW-1:0]    div_d;

    // positions
    logic [XW-1:0]    in_col_reg;
    logic [RW-1:0]    in_row_reg;
    logic [XW-1:0]    ox_reg;
    logic [YW-1:0]    oy_reg;

    // sequencer and job
    state_t           state_reg, state_next;
    logic             vmode_reg;
    logic [XW-1:0]    hx_reg;
    logic [XW-1:0]    hx_end_reg;
    logic [YW-1:0]    hrow_reg;
    logic signed [PW-1:0] pos_reg;
    logic [DW-1:0]    tap_reg;
    logic             rd_use_reg;
    logic [2:0]       step_reg;
    logic [SUMW-1:0]  acc_reg [4];
    logic [7:0]       quo_reg [4];
    logic             m_valid_reg;
    logic [31:0]      out_data_reg;
    logic             out_last_reg;

    // memories
    logic [31:0]      row_mem  [MAX_WIDTH];
    logic [31:0]      line_mem [2**LSAW];
    logic [31:0]      rw_q_reg;
    logic [31:0]      ls_q_reg;

    // combinational
    logic             accept;
    logic             push;
    logic             w_last_col;
    logic             col_ge_r;
    logic             h_job;
    logic [XW-1:0]    hx_start;
    logic [XW-1:0]    hx_stop;
    logic [PW-1:0]    oy_span, h_top, nrow, ox_span, w_top, ncol;
    logic             out_ready;
    logic             frame_last;
    logic signed [PW-1:0] lim;
    logic             below, above, tap_ok;
    logic signed [PW-1:0] tap_pos;
    logic             tap_last;
    logic [SUMW-1:0]  trial;
    logic             div_ge [4];
    logic [31:0]      rd_data;
    logic             row_rd, line_rd, line_wr, emit_go;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = CW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_reg);
        if (height_reg == '0)
            h_eff = RW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(height_reg);
        if (32'(radius_reg) > MAX_RADIUS)
            r_eff = RADW'(MAX_RADIUS);
        else
            r_eff = RADW'(radius_reg);
        div_d = DW'({r_eff, 1'b1});
    end

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign push       = accept && (s_axis_tuser == FUNC_PUSH) && (in_row_reg < h_eff);
    assign w_last_col = (CW'(in_col_reg) == w_eff - CW'(1));
    assign col_ge_r   = (PW'(in_col_reg) >= PW'(r_eff));
    assign h_job      = push && (col_ge_r || w_last_col);
    assign hx_start   = col_ge_r ? XW'(PW'(in_col_reg) - PW'(r_eff)) : '0;
    assign hx_stop    = w_last_col ? in_col_reg : hx_start;

    // last tap row and column of the next result
    always_comb
    begin
        oy_span = PW'(oy_reg) + PW'(r_eff);
        h_top   = PW'(h_eff) - PW'(1);
        nrow    = (oy_span < h_top) ? oy_span : h_top;
        ox_span = PW'(ox_reg) + PW'(r_eff);
        w_top   = PW'(w_eff) - PW'(1);
        ncol    = (ox_span < w_top) ? ox_span : w_top;
        out_ready = (PW'(in_row_reg) > nrow)
                 || ((PW'(in_row_reg) == nrow) && (PW'(in_col_reg) > ncol));
    end

    assign frame_last = (CW'(ox_reg) == w_eff - CW'(1)) && (RW'(oy_reg) == h_eff - RW'(1));

    // tap position, clamped or skipped at the edges
    always_comb
    begin
        lim    = vmode_reg ? PW'(h_eff) : PW'(w_eff);
        below  = (pos_reg < 0);
        above  = (pos_reg >= lim);
        tap_ok = !(below || above) || repeat_reg;
        if (below)
            tap_pos = '0;
        else if (above)
            tap_pos = lim - PW'(1);
        else
            tap_pos = pos_reg;
    end

    assign tap_last = (tap_reg == DW'({r_eff, 1'b0}));
    assign trial    = SUMW'(div_d) << step_reg;
    assign rd_data  = vmode_reg ? ls_q_reg : rw_q_reg;

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
            div_ge[ch] = (acc_reg[ch] >= trial);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = h_job ? S_TAP : S_CHECK;
            end
            S_CHECK: state_next = out_ready ? S_TAP : S_IDLE;
            S_TAP:   state_next = tap_last ? S_FLUSH : S_TAP;
            S_FLUSH: state_next = S_DIV;
            S_DIV:
            begin
                if (step_reg == '0)
                    state_next = vmode_reg ? S_EMIT : S_STORE;
            end
            S_STORE: state_next = (hx_reg == hx_end_reg) ? S_CHECK : S_TAP;
            S_EMIT:
            begin
                if (emit_go)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        row_rd        = (state_reg == S_TAP) && !vmode_reg && tap_ok;
        line_rd       = (state_reg == S_TAP) && vmode_reg && tap_ok;
        line_wr       = (state_reg == S_STORE);
        emit_go       = (state_reg == S_EMIT) && (!m_valid_reg || m_axis_tready);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
            radius_reg  <= RADIUS_RST;
            repeat_reg  <= REPEAT_RST;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            rd_use_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_use_reg <= row_rd || line_rd;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                    CFG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                    CFG_BLUR_RADIUS:  radius_reg <= cfg_wdata[3:0];
                    CFG_REPEAT_EDGES: repeat_reg <= cfg_wdata[0];
                endcase
                in_col_reg <= '0;
                in_row_reg <= '0;
                ox_reg     <= '0;
                oy_reg     <= '0;
            end
            else
            begin
                if (push)
                begin
                    if (w_last_col)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + RW'(1);
                    end
                    else
                        in_col_reg <= in_col_reg + XW'(1);
                end
                if (emit_go)
                begin
                    if (frame_last)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= '0;
                        ox_reg     <= '0;
                        oy_reg     <= '0;
                    end
                    else if (CW'(ox_reg) == w_eff - CW'(1))
                    begin
                        ox_reg <= '0;
                        oy_reg <= oy_reg + YW'(1);
                    end
                    else
                        ox_reg <= ox_reg + XW'(1);
                end
            end
            if (emit_go)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // job datapath
    always_ff @(posedge clk)
    begin
        if (rd_use_reg)
        begin
            for (int ch = 0; ch < 4; ch++)
                acc_reg[ch] <= acc_reg[ch] + SUMW'(rd_data[8*ch +: 8]);
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    vmode_reg  <= 1'b0;
                    hx_reg     <= hx_start;
                    hx_end_reg <= hx_stop;
                    hrow_reg   <= YW'(in_row_reg);
                    pos_reg    <= $signed(PW'(hx_start)) - $signed(PW'(r_eff));
                    tap_reg    <= '0;
                    for (int ch = 0; ch < 4; ch++)
                        acc_reg[ch] <= '0;
                end
            end
            S_CHECK:
            begin
                vmode_reg <= 1'b1;
                pos_reg   <= $signed(PW'(oy_reg)) - $signed(PW'(r_eff));
                tap_reg   <= '0;
                for (int ch = 0; ch < 4; ch++)
                    acc_reg[ch] <= '0;
            end
            S_TAP:
            begin
                pos_reg <= pos_reg + PW'(1);
                tap_reg <= tap_reg + DW'(1);
            end
            S_FLUSH:
            begin
                step_reg <= 3'd7;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit per cycle, msb first
                for (int ch = 0; ch < 4; ch++)
                begin
                    if (div_ge[ch])
                        acc_reg[ch] <= acc_reg[ch] - trial;
                    quo_reg[ch] <= {quo_reg[ch][6:0], div_ge[ch]};
                end
                step_reg <= step_reg - 3'd1;
            end
            S_STORE:
            begin
                if (hx_reg != hx_end_reg)
                begin
                    hx_reg  <= hx_reg + XW'(1);
                    pos_reg <= $signed(PW'(hx_reg)) + PW'(1) - $signed(PW'(r_eff));
                    tap_reg <= '0;
                    for (int ch = 0; ch < 4; ch++)
                        acc_reg[ch] <= '0;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_data_reg <= {quo_reg[3], quo_reg[2], quo_reg[1], quo_reg[0]};
                    out_last_reg <= frame_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    // source row buffer
    always_ff @(posedge clk)
    begin
        if (push)
            row_mem[in_col_reg] <= s_axis_tdata;
        if (row_rd)
            rw_q_reg <= row_mem[tap_pos[XW-1:0]];
    end

    // horizontal results, one slot per row modulo the slot count
    always_ff @(posedge clk)
    begin
        if (line_wr)
            line_mem[{SLOTW'(hrow_reg), hx_reg}] <=
                {quo_reg[3], quo_reg[2], quo_reg[1], quo_reg[0]};
        if (line_rd)
            ls_q_reg <= line_mem[{tap_pos[SLOTW-1:0], ox_reg}];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted item did not start the sequencer");

    a_input_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= h_eff)
        else $error("input position ran past the frame");

    a_read_in_tap_loop: assert property (@(posedge clk) disable iff (!rst_n)
        rd_use_reg |-> (state_reg == S_TAP || state_reg == S_FLUSH))
        else $error("memory read data used outside the tap loop");

endmodule

// ===== dv/separable_box_blur_top_tb.sv =====
// testbench of the separable box blur: stream stimulus, cycle-free predictor, scoreboard check
`timescale 1ns / 100ps

module separable_box_blur_top_tb;
    import sbb_pkg::*;

    localparam logic FUNC_DRAIN   = 1'b1;
    localparam int   IDLE_LIMIT   = 40000;
    localparam int   HOLD_OFF     = 1200;
    localparam int   RANDOM_ITEMS = 700;

    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
    } blur_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    separable_box_blur_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // blur predictor state
    logic [10:0]  blur_w_reg;
    logic [10:0]  blur_h_reg;
    logic [3:0]   blur_r_reg;
    logic         blur_rep_reg;
    int unsigned  pix_in_count;
    int unsigned  pix_out_count;
    logic [31:0]  row_pixels [MAX_WIDTH_DEF];
    logic [31:0]  hblur_store [int unsigned];

    blur_result_t pending_pixels[$];
    int           error_count;
    int           items_sent;
    bit           send_gaps;
    bit           sink_stalls;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned frame_w();
        if (blur_w_reg == 0) return 1;
        return (blur_w_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : blur_w_reg;
    endfunction

    function automatic int unsigned frame_h();
        if (blur_h_reg == 0) return 1;
        return (blur_h_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : blur_h_reg;
    endfunction

    function automatic int unsigned frame_r();
        return (blur_r_reg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : blur_r_reg;
    endfunction

    // clamp or skip a tap; returns 0 when skipped
    function automatic bit tap_pos(int pos, int lim, output int idx);
        if (pos < 0 || pos >= lim)
        begin
            if (!blur_rep_reg) return 0;
            pos = (pos < 0) ? 0 : lim - 1;
        end
        idx = pos;
        return 1;
    endfunction

    function automatic logic [31:0] channel_average(longint s0, longint s1, longint s2,
                                                    longint s3, int unsigned div);
        logic [31:0] v;
        v[7:0]   = 8'(s0 / div);
        v[15:8]  = 8'(s1 / div);
        v[23:16] = 8'(s2 / div);
        v[31:24] = 8'(s3 / div);
        return v;
    endfunction

    function automatic void hblur(int unsigned x, int unsigned y, int unsigned w,
                                  int unsigned r);
        longint s0, s1, s2, s3;
        int idx;
        logic [31:0] p;
        s0 = 0; s1 = 0; s2 = 0; s3 = 0;
        for (int d = -int'(r); d <= int'(r); d++)
        begin
            if (tap_pos(int'(x) + d, int'(w), idx))
            begin
                p = row_pixels[idx];
                s0 += p[7:0]; s1 += p[15:8]; s2 += p[23:16]; s3 += p[31:24];
            end
        end
        hblur_store[y * w + x] = channel_average(s0, s1, s2, s3, 2 * r + 1);
    endfunction

    function automatic void predict_blur(logic func, logic [31:0] pix);
        int unsigned w, h, r, total, n, ox, oy, nrow, ncol, c, y;
        longint s0, s1, s2, s3;
        int idx;
        logic [31:0] p;
        blur_result_t res;
        w = frame_w(); h = frame_h(); r = frame_r();
        total = w * h;
        if (func == FUNC_PUSH && pix_in_count < total)
        begin
            c = pix_in_count % w;
            y = pix_in_count / w;
            row_pixels[c] = pix;
            if (c >= r) hblur(c - r, y, w, r);
            if (c == w - 1)
                for (int unsigned x = (w > r) ? w - r : 0; x < w; x++)
                    hblur(x, y, w, r);
            pix_in_count++;
        end
        n = pix_out_count;
        ox = n % w;
        oy = n / w;
        nrow = (oy + r < h - 1) ? oy + r : h - 1;
        ncol = (ox + r < w - 1) ? ox + r : w - 1;
        if (pix_in_count <= nrow * w + ncol) return;
        s0 = 0; s1 = 0; s2 = 0; s3 = 0;
        for (int d = -int'(r); d <= int'(r); d++)
        begin
            if (tap_pos(int'(oy) + d, int'(h), idx))
            begin
                p = hblur_store[idx * w + ox];
                s0 += p[7:0]; s1 += p[15:8]; s2 += p[23:16]; s3 += p[31:24];
            end
        end
        res.pixel = channel_average(s0, s1, s2, s3, 2 * r + 1);
        res.last  = (n == total - 1);
        pending_pixels.push_back(res);
        if (res.last)
        begin
            pix_in_count  = 0;
            pix_out_count = 0;
        end
        else
            pix_out_count = n + 1;
    endfunction

    // one item; leaves tvalid high, callers lower it before pausing
    task automatic send_item(logic func, logic [31:0] pix);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= func;
        do @(posedge clk); while (!s_axis_tready);
        predict_blur(func, pix);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge clk);
    endtask

    // registers change only with the block idle
    task automatic write_config(logic [10:0] w, logic [10:0] h, logic [3:0] r, logic rep);
        wait_drained();
        repeat (HOLD_OFF) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;  cfg_wdata <= w;
        @(negedge clk);
        cfg_index <= CFG_FRAME_HEIGHT; cfg_wdata <= h;
        @(negedge clk);
        cfg_index <= CFG_BLUR_RADIUS;  cfg_wdata <= CFG_DATA_W'(r);
        @(negedge clk);
        cfg_index <= CFG_REPEAT_EDGES; cfg_wdata <= CFG_DATA_W'(rep);
        @(negedge clk);
        cfg_we <= 1'b0;
        blur_w_reg = w; blur_h_reg = h; blur_r_reg = r; blur_rep_reg = rep;
        pix_in_count = 0;
        pix_out_count = 0;
    endtask

    task automatic finish_frame();
        do send_item(FUNC_DRAIN, $urandom); while (pix_in_count != 0 || pix_out_count != 0);
    endtask

    task automatic random_frame(int unsigned drain_odds);
        int unsigned total;
        total = frame_w() * frame_h();
        for (int unsigned i = 0; i < total; i++)
        begin
            if ($urandom_range(0, drain_odds) == 0) send_item(FUNC_DRAIN, $urandom);
            send_item(FUNC_PUSH, $urandom);
        end
        finish_frame();
    endtask

    task automatic test_directed();
        write_config(11'd3, 11'd2, 4'd1, 1'b0);
        send_item(FUNC_DRAIN, 32'h0);
        send_item(FUNC_PUSH, 32'hFFFF_FFFF);
        send_item(FUNC_PUSH, 32'h0000_0000);
        send_item(FUNC_PUSH, 32'hFF00_FF00);
        send_item(FUNC_PUSH, 32'h00FF_00FF);
        send_item(FUNC_PUSH, 32'hFFFF_FFFF);
        send_item(FUNC_PUSH, 32'h8040_2010);
        // pushes into a full frame only drain
        send_item(FUNC_PUSH, 32'h1234_5678);
        finish_frame();
        // zero width and height act as one pixel
        write_config(11'd0, 11'd0, 4'd0, 1'b1);
        send_item(FUNC_PUSH, 32'hA5A5_5A5A);
        send_item(FUNC_PUSH, 32'hFFFF_FFFF);
        finish_frame();
        write_config(11'd4, 11'd3, 4'd15, 1'b1);
        for (int i = 0; i < 12; i++) send_item(FUNC_PUSH, (i % 2) ? 32'hFFFF_FFFF : 32'h0);
        finish_frame();
        // a register write mid-frame restarts it
        write_config(11'd5, 11'd5, 4'd2, 1'b0);
        repeat (3) send_item(FUNC_PUSH, $urandom);
        write_config(11'd5, 11'd5, 4'd2, 1'b0);
        random_frame(7);
    endtask

    task automatic test_big_frames();
        write_config(11'd2047, 11'd1, 4'd3, 1'b1);
        random_frame(50);
        // height above the maximum, cut short by the next register write
        write_config(11'd1, 11'd2047, 4'd2, 1'b0);
        repeat (64) send_item(FUNC_PUSH, $urandom);
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned total;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            write_config(11'($urandom_range(0, 12)), 11'($urandom_range(0, 8)),
                         ($urandom_range(0, 3) == 0) ? 4'd15 : 4'($urandom_range(0, 4)),
                         1'($urandom));
            total = frame_w() * frame_h();
            if ($urandom_range(0, 9) == 0)
            begin
                // broken frame, cut short by a register write
                for (int unsigned i = 0; i < $urandom_range(0, total); i++)
                    send_item(1'($urandom), $urandom);
                continue;
            end
            for (int unsigned i = 0; i < total; i++)
            begin
                if ($urandom_range(0, 7) == 0) send_item(FUNC_DRAIN, $urandom);
                if ($urandom_range(0, 40) == 0) wait_drained();
                send_item(FUNC_PUSH, $urandom);
            end
            finish_frame();
        end
    endtask

    task automatic test_steady();
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        repeat (4)
        begin
            write_config(11'($urandom_range(1, 9)), 11'($urandom_range(1, 6)),
                         4'($urandom_range(0, 3)), 1'($urandom));
            random_frame(5);
        end
    endtask

    // result sink, with random stalls while sink_stalls is set
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        blur_result_t exp_px;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                if (m_axis_tdata !== exp_px.pixel || m_axis_tlast !== exp_px.last)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                                 exp_px.pixel, exp_px.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int unsigned quiet_cycles;
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("separable_box_blur_top_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        error_count = 0;
        items_sent = 0;
        send_gaps = 1'b1;
        sink_stalls = 1'b1;
        blur_w_reg = WIDTH_RST;
        blur_h_reg = HEIGHT_RST;
        blur_r_reg = RADIUS_RST;
        blur_rep_reg = REPEAT_RST;
        pix_in_count = 0;
        pix_out_count = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_big_frames();
        test_random_frames();
        test_steady();

        wait_drained();
        repeat (HOLD_OFF) @(posedge clk);
        if (error_count == 0 && pending_pixels.size() == 0)
            $display("separable_box_blur_top_tb: done, clean");
        else
            $display("separable_box_blur_top_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/sbb_pkg.sv
design/separable_box_blur_top.sv
dv/separable_box_blur_top_tb.sv
